// File: rtl/swrl_pkg.sv
package swrl_pkg;

  localparam int CLIENT_SLOTS_DEF     = 16;
  localparam int EXT_LOG_DEPTH_DEF    = 256;
  localparam int REPORT_LOG_DEPTH_DEF = 4;
  localparam int TIER_COUNT_DEF       = 3;

  localparam logic [15:0] EXT_WIN_RST  = 16'd1000;
  localparam logic [8:0]  TIER_LOW_RST = 9'd50;
  localparam logic [8:0]  TIER_MID_RST = 9'd100;
  localparam logic [8:0]  TIER_HI_RST  = 9'd200;
  localparam logic [15:0] REP_WIN_RST  = 16'd5000;
  localparam logic [2:0]  REP_MAX_RST  = 3'd1;

  typedef enum logic [2:0] {
    CFG_EXT_WIN  = 3'd0,
    CFG_TIER_LOW = 3'd1,
    CFG_TIER_MID = 3'd2,
    CFG_TIER_HI  = 3'd3,
    CFG_REP_WIN  = 3'd4,
    CFG_REP_MAX  = 3'd5
  } cfg_idx_t;

  localparam logic REQ_EXT = 1'b0;
  localparam logic REQ_REP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] client_id;
    logic [1:0]  tier_index;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic       limited;
    logic [8:0] tier_hit;
    logic       table_full;
  } rsp_t;

  typedef enum logic [2:0] {
    RES_BADTIER,
    RES_FULL,
    RES_EXT,
    RES_REP_OK,
    RES_REP_SUPP
  } res_t;

  typedef struct packed {
    logic latch;
    logic scan_clr;
    logic scan_inc;
    logic tier_clr;
    logic tier_inc;
    logic tier_load;
    logic rd_oldest;
    logic take;
    logic pop;
    logic push;
    logic load_out;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic bad_tier;
    logic is_rep;
    logic match;
    logic slot_vld;
    logic scan_last;
    logic tier_last;
    logic ext_nz;
    logic rep_nz;
    logic ext_live;
    logic rep_live;
    logic act_nz;
    logic act_stale;
    logic rep_full;
    logic out_busy;
  } status_t;

  function automatic int swrl_w(input int n);
    return (n <= 1) ? 1 : $clog2(n);
  endfunction

endpackage

// File: rtl/swrl_ram.sv
module swrl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [swrl_pkg::swrl_w(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [swrl_pkg::swrl_w(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import swrl_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/swrl_ctrl.sv
module swrl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  swrl_pkg::status_t st,
  output swrl_pkg::cmd_t    cmd
);
  import swrl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MATCH,
    S_FREE,
    S_FREE_EW,
    S_FREE_R,
    S_FREE_RW,
    S_TAKE,
    S_EXP,
    S_EXP_W,
    S_ACT,
    S_FIN
  } state_t;

  state_t state, state_next;
  res_t   res, res_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.res    = res;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch    = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.bad_tier) begin
          res_next   = RES_BADTIER;
          state_next = S_FIN;
        end else begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        if (st.match) begin
          cmd.tier_load = 1'b1;
          state_next    = S_EXP;
        end else if (st.scan_last) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_FREE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_FREE: begin
        if (!st.slot_vld) begin
          state_next = S_TAKE;
        end else if (st.ext_nz) begin
          state_next = S_FREE_EW;
        end else begin
          cmd.tier_clr = 1'b1;
          state_next   = S_FREE_R;
        end
      end
      S_FREE_EW: begin
        if (st.ext_live) begin
          if (st.scan_last) begin
            res_next   = RES_FULL;
            state_next = S_FIN;
          end else begin
            cmd.scan_inc = 1'b1;
            state_next   = S_FREE;
          end
        end else begin
          cmd.tier_clr = 1'b1;
          state_next   = S_FREE_R;
        end
      end
      S_FREE_R: begin
        if (st.rep_nz) begin
          state_next = S_FREE_RW;
        end else if (st.tier_last) begin
          state_next = S_TAKE;
        end else begin
          cmd.tier_inc = 1'b1;
        end
      end
      S_FREE_RW: begin
        if (st.rep_live) begin
          if (st.scan_last) begin
            res_next   = RES_FULL;
            state_next = S_FIN;
          end else begin
            cmd.scan_inc = 1'b1;
            state_next   = S_FREE;
          end
        end else if (st.tier_last) begin
          state_next = S_TAKE;
        end else begin
          cmd.tier_inc = 1'b1;
          state_next   = S_FREE_R;
        end
      end
      S_TAKE: begin
        cmd.take      = 1'b1;
        cmd.tier_load = 1'b1;
        state_next    = S_EXP;
      end
      S_EXP: begin
        if (st.act_nz) begin
          cmd.rd_oldest = 1'b1;
          state_next    = S_EXP_W;
        end else begin
          state_next = S_ACT;
        end
      end
      S_EXP_W: begin
        if (st.act_stale) begin
          cmd.pop    = 1'b1;
          state_next = S_EXP;
        end else begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        if (st.is_rep && st.rep_full) begin
          res_next = RES_REP_SUPP;
        end else begin
          cmd.push = 1'b1;
          res_next = st.is_rep ? RES_REP_OK : RES_EXT;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_FULL;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

endmodule

// File: rtl/swrl_dp.sv
module swrl_dp #(
  parameter int CLIENT_SLOTS     = swrl_pkg::CLIENT_SLOTS_DEF,
  parameter int EXT_LOG_DEPTH    = swrl_pkg::EXT_LOG_DEPTH_DEF,
  parameter int REPORT_LOG_DEPTH = swrl_pkg::REPORT_LOG_DEPTH_DEF,
  parameter int TIER_COUNT       = swrl_pkg::TIER_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  swrl_pkg::req_t    req,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output swrl_pkg::rsp_t    rsp,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  swrl_pkg::cmd_t    cmd,
  output swrl_pkg::status_t st
);
  import swrl_pkg::*;

  localparam int D     = EXT_LOG_DEPTH;
  localparam int R     = REPORT_LOG_DEPTH;
  localparam int SW    = swrl_w(CLIENT_SLOTS);
  localparam int EH_W  = swrl_w(D);
  localparam int EF_W  = $clog2(D + 1);
  localparam int EA_W  = swrl_w(CLIENT_SLOTS * D);
  localparam int RH_W  = swrl_w(R);
  localparam int RF_W  = $clog2(R + 1);
  localparam int KN    = CLIENT_SLOTS * TIER_COUNT;
  localparam int K_W   = swrl_w(KN);
  localparam int RA_W  = swrl_w(KN * R);
  localparam int TW    = (EF_W > 9) ? EF_W : 9;
  localparam int CW    = (RF_W > 3) ? RF_W : 3;

  logic [15:0] ext_win, rep_win;
  logic [8:0]  th [3];
  logic [2:0]  rep_max;

  req_t r;
  rsp_t rsp_next;
  logic [SW-1:0] scan;
  logic [1:0]    tcnt;

  logic                              slot_valid  [CLIENT_SLOTS];
  logic [31:0]                       slot_client [CLIENT_SLOTS];
  logic [EH_W-1:0]                   ext_head    [CLIENT_SLOTS];
  logic [EF_W-1:0]                   ext_fill    [CLIENT_SLOTS];
  logic [TIER_COUNT-1:0][RH_W-1:0]   rep_head    [CLIENT_SLOTS];
  logic [TIER_COUNT-1:0][RF_W-1:0]   rep_fill    [CLIENT_SLOTS];

  logic [K_W-1:0]    k;
  logic [EH_W-1:0]   eh, e_new, e_old, e_idx, eh_inc;
  logic [EF_W-1:0]   ef;
  logic [EF_W:0]     e_tmp;
  logic [RH_W-1:0]   rh, r_new, r_old, r_idx, rh_inc;
  logic [RF_W-1:0]   rf;
  logic [RF_W:0]     r_tmp;
  logic [EA_W-1:0]   e_base, e_raddr, e_waddr;
  logic [RA_W-1:0]   r_base, r_raddr, r_waddr;
  logic [47:0]       e_rdata, r_rdata;
  logic [48:0]       e_sum, r_sum;
  logic              e_stale, r_stale;
  logic              hit_lim;
  logic [8:0]        hit_val;

  assign k  = K_W'(scan) * K_W'(TIER_COUNT) + K_W'(tcnt);
  assign eh = ext_head[scan];
  assign ef = ext_fill[scan];
  assign rh = rep_head[scan][tcnt];
  assign rf = rep_fill[scan][tcnt];

  always_comb begin
    e_new  = (eh == '0) ? EH_W'(D - 1) : eh - EH_W'(1);
    eh_inc = (eh == EH_W'(D - 1)) ? '0 : eh + EH_W'(1);
    e_tmp  = (EF_W + 1)'(eh) + (EF_W + 1)'(D) - (EF_W + 1)'(ef);
    if (e_tmp >= (EF_W + 1)'(D)) begin
      e_tmp = e_tmp - (EF_W + 1)'(D);
    end
    e_old  = EH_W'(e_tmp);
    e_idx  = cmd.rd_oldest ? e_old : e_new;
    r_new  = (rh == '0) ? RH_W'(R - 1) : rh - RH_W'(1);
    rh_inc = (rh == RH_W'(R - 1)) ? '0 : rh + RH_W'(1);
    r_tmp  = (RF_W + 1)'(rh) + (RF_W + 1)'(R) - (RF_W + 1)'(rf);
    if (r_tmp >= (RF_W + 1)'(R)) begin
      r_tmp = r_tmp - (RF_W + 1)'(R);
    end
    r_old  = RH_W'(r_tmp);
    r_idx  = cmd.rd_oldest ? r_old : r_new;
  end

  assign e_base  = EA_W'(scan) * EA_W'(D);
  assign e_raddr = e_base + EA_W'(e_idx);
  assign e_waddr = e_base + EA_W'(eh);
  assign r_base  = RA_W'(k) * RA_W'(R);
  assign r_raddr = r_base + RA_W'(r_idx);
  assign r_waddr = r_base + RA_W'(rh);

  swrl_ram #(.WIDTH(48), .DEPTH(CLIENT_SLOTS * D)) u_ext_ram (
    .clk   (clk),
    .we    (cmd.push && !r.req_type),
    .waddr (e_waddr),
    .wdata (r.now_ms),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  swrl_ram #(.WIDTH(48), .DEPTH(KN * R)) u_rep_ram (
    .clk   (clk),
    .we    (cmd.push && r.req_type),
    .waddr (r_waddr),
    .wdata (r.now_ms),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  assign e_sum   = {1'b0, e_rdata} + 49'(ext_win);
  assign r_sum   = {1'b0, r_rdata} + 49'(rep_win);
  assign e_stale = e_sum < {1'b0, r.now_ms};
  assign r_stale = r_sum < {1'b0, r.now_ms};

  always_comb begin
    hit_lim = 1'b0;
    hit_val = '0;
    for (int t = 0; t < 3; t++) begin
      if (t < TIER_COUNT && TW'(ef) >= TW'(th[t])) begin
        hit_lim = 1'b1;
        hit_val = th[t];
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    case (cmd.res)
      RES_BADTIER:  rsp_next.limited = 1'b1;
      RES_FULL:     rsp_next.table_full = 1'b1;
      RES_EXT: begin
        rsp_next.limited  = hit_lim;
        rsp_next.tier_hit = hit_val;
      end
      RES_REP_SUPP: rsp_next.limited = 1'b1;
      default:      rsp_next.limited = 1'b0;
    endcase
  end

  always_comb begin
    st.bad_tier  = r.req_type && (32'(r.tier_index) >= TIER_COUNT);
    st.is_rep    = r.req_type;
    st.match     = slot_valid[scan] && (slot_client[scan] == r.client_id);
    st.slot_vld  = slot_valid[scan];
    st.scan_last = (scan == SW'(CLIENT_SLOTS - 1));
    st.tier_last = (32'(tcnt) == TIER_COUNT - 1);
    st.ext_nz    = (ef != '0);
    st.rep_nz    = (rf != '0);
    st.ext_live  = !e_stale;
    st.rep_live  = !r_stale;
    st.act_nz    = r.req_type ? (rf != '0) : (ef != '0);
    st.act_stale = r.req_type ? r_stale : e_stale;
    st.rep_full  = CW'(rf) >= CW'(rep_max);
    st.out_busy  = rsp_valid && !rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r <= req;
    end
    if (cmd.load_out) begin
      rsp <= rsp_next;
    end
    if (cmd.take) begin
      slot_client[scan] <= r.client_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_win   <= EXT_WIN_RST;
      th[0]     <= TIER_LOW_RST;
      th[1]     <= TIER_MID_RST;
      th[2]     <= TIER_HI_RST;
      rep_win   <= REP_WIN_RST;
      rep_max   <= REP_MAX_RST;
      rsp_valid <= 1'b0;
      scan      <= '0;
      tcnt      <= '0;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        ext_head[i]   <= '0;
        ext_fill[i]   <= '0;
        rep_head[i]   <= '0;
        rep_fill[i]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_EXT_WIN:  ext_win <= cfg_data;
          CFG_TIER_LOW: th[0]   <= cfg_data[8:0];
          CFG_TIER_MID: th[1]   <= cfg_data[8:0];
          CFG_TIER_HI:  th[2]   <= cfg_data[8:0];
          CFG_REP_WIN:  rep_win <= cfg_data;
          CFG_REP_MAX:  rep_max <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.scan_clr) begin
        scan <= '0;
      end else if (cmd.scan_inc) begin
        scan <= scan + SW'(1);
      end
      if (cmd.tier_clr) begin
        tcnt <= '0;
      end else if (cmd.tier_inc) begin
        tcnt <= tcnt + 2'd1;
      end else if (cmd.tier_load) begin
        tcnt <= r.tier_index;
      end
      if (cmd.take) begin
        slot_valid[scan] <= 1'b1;
        ext_head[scan]   <= '0;
        ext_fill[scan]   <= '0;
        rep_head[scan]   <= '0;
        rep_fill[scan]   <= '0;
      end
      if (cmd.pop) begin
        if (r.req_type) begin
          rep_fill[scan][tcnt] <= rf - RF_W'(1);
        end else begin
          ext_fill[scan] <= ef - EF_W'(1);
        end
      end
      if (cmd.push) begin
        if (r.req_type) begin
          rep_head[scan][tcnt] <= rh_inc;
          if (rf != RF_W'(R)) begin
            rep_fill[scan][tcnt] <= rf + RF_W'(1);
          end
        end else begin
          ext_head[scan] <= eh_inc;
          if (ef != EF_W'(D)) begin
            ext_fill[scan] <= ef + EF_W'(1);
          end
        end
      end
    end
  end

  a_ext_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ef <= EF_W'(D))
    else $error("extension log fill above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (r.req_type ? (rf != '0) : (ef != '0)))
    else $error("pop from empty log");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(rsp_valid && !rsp_ready))
    else $error("result register overwritten while stalled");

endmodule

// File: rtl/sliding_window_tiered_rate_limiter.sv
// Per-client sliding-window rate limiter with tiered thresholds.
// req channel (req_valid/req_ready/req): one request item, extension
// check or report check. rsp channel (rsp_valid/rsp_ready/rsp): exactly
// one result item per request, in request order.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
// always ready; write only while no request is in flight.
// One request at a time. After acceptance the request is latched and its
// tier index checked, then the client table is walked for an id match;
// when a new slot is needed, all CLIENT_SLOTS entries are matched first,
// then each slot inspected has its logs' newest stamps read, each read a
// registered memory read, until a free slot is found and taken.
// A nonempty log then has its oldest stamp read, and expiry drops each
// stale stamp, with a new read through the log memory read port per stamp.
// A bad tier index returns after the check; a full table after the walk.
// A result sits in an output register; the next request is taken while it
// waits, and a following result waits in the controller until it drains.
// Reset (synchronous, rst) empties the client table and all logs and
// restores the default register values; stamp memories need no clearing.
module sliding_window_tiered_rate_limiter #(
  parameter int CLIENT_SLOTS     = swrl_pkg::CLIENT_SLOTS_DEF,
  parameter int EXT_LOG_DEPTH    = swrl_pkg::EXT_LOG_DEPTH_DEF,
  parameter int REPORT_LOG_DEPTH = swrl_pkg::REPORT_LOG_DEPTH_DEF,
  parameter int TIER_COUNT       = swrl_pkg::TIER_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  swrl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output swrl_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import swrl_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  swrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  swrl_dp #(
    .CLIENT_SLOTS     (CLIENT_SLOTS),
    .EXT_LOG_DEPTH    (EXT_LOG_DEPTH),
    .REPORT_LOG_DEPTH (REPORT_LOG_DEPTH),
    .TIER_COUNT       (TIER_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
